### sv/sc2x_pkg.sv
// Shared constants and types of the Scale2x pixel upscaler.
package sc2x_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int PIXEL_BITS_DEF = 32;
	localparam int MAX_ROWS       = 4096;
	localparam int QUEUE_DEPTH    = 4;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 13;

	localparam logic [12:0] FRAME_WIDTH_RST  = 13'd320;
	localparam logic [12:0] FRAME_HEIGHT_RST = 13'd240;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_PIXEL_FORMAT = 2'd2
	} cfg_reg_t;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	typedef struct packed {
		logic        is_drain;
		logic        emit;
		logic        has_upper;
		logic        last;
		logic        done;
		logic [11:0] brow;
	} item_ctrl_t;

endpackage

### sv/scale2x_pixel_upscaler.sv
// Top level of the streaming Scale2x pixel-art upscaler.
// A beat passes the queue, the stage-two registers and the result register, and waits
// longer while earlier beats wait in the queue or the result is stalled.
// Throughput: one input beat per cycle unless the result is stalled, set by the
// single read and write port of each line buffer being used once per pixel.
// Reset clears counters, queue and valid flags; line buffers are not cleared.
module scale2x_pixel_upscaler
	import sc2x_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [31:0]           s_axis_tdata,  // pixel_value
	input  logic                  s_axis_tuser,  // mode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// top_left, top_right, bottom_left, bottom_right, block_column, block_row
	output logic [151:0]          m_axis_tdata,
	output logic                  m_axis_tlast   // frame_done
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int QW    = $bits(item_ctrl_t) + 2 * COL_W + PIXEL_BITS;

	logic                  f_valid, f_ready, q_valid, q_ready;
	item_ctrl_t            f_ctrl, q_ctrl;
	logic [COL_W-1:0]      f_x, f_nxt, q_x, q_nxt;
	logic [PIXEL_BITS-1:0] f_px, q_px;
	logic [QW-1:0]         q_out;
	logic [PIXEL_BITS-1:0] tl, tr, bl, br;
	logic [11:0]           col, row;

	sc2x_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_mode    (s_axis_tuser),
		.in_pixel   (s_axis_tdata),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item_ctrl  (f_ctrl),
		.item_x     (f_x),
		.item_nxt   (f_nxt),
		.item_px    (f_px)
	);

	sc2x_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   ({f_ctrl, f_x, f_nxt, f_px}),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_out)
	);

	assign {q_ctrl, q_x, q_nxt, q_px} = q_out;

	sc2x_back #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.item_ctrl  (q_ctrl),
		.item_x     (q_x),
		.item_nxt   (q_nxt),
		.item_px    (q_px),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_tl     (tl),
		.res_tr     (tr),
		.res_bl     (bl),
		.res_br     (br),
		.res_col    (col),
		.res_row    (row),
		.res_done   (m_axis_tlast)
	);

	assign m_axis_tdata = {row, col, 32'(br), 32'(bl), 32'(tr), 32'(tl)};

endmodule

### sv/sc2x_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module sc2x_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/sc2x_fifo.sv
// Short queue between the classifying front and the filter back end.
module sc2x_fifo #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign in_ready  = count_q != CNT_W'(DEPTH);
	assign out_valid = count_q != '0;
	assign out_data  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

### sv/sc2x_front.sv
// Front end: configuration registers, raster counters and beat classification.
module sc2x_front
	import sc2x_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_mode,
	input  logic [31:0]                  in_pixel,
	output logic                         item_valid,
	input  logic                         item_ready,
	output item_ctrl_t                   item_ctrl,
	output logic [$clog2(MAX_WIDTH)-1:0] item_x,
	output logic [$clog2(MAX_WIDTH)-1:0] item_nxt,
	output logic [PIXEL_BITS-1:0]        item_px
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic [12:0]      fw_q, fh_q;
	logic             fmt_q;
	logic [COL_W-1:0] col_q;
	logic [12:0]      row_q;
	logic             drain_q;

	logic [31:0]           fw32, fh32;
	logic [COL_W-1:0]      last_col;
	logic [11:0]           last_row;
	logic                  last, row_last, effective, accepted;
	logic [PIXEL_BITS-1:0] mask;

	always_comb begin
		fw32 = 32'(fw_q);
		fh32 = 32'(fh_q);
		if (fw32 == 32'd0) begin
			last_col = '0;
		end else if (fw32 > 32'(MAX_WIDTH)) begin
			last_col = COL_W'(MAX_WIDTH - 1);
		end else begin
			last_col = COL_W'(fw32 - 32'd1);
		end
		if (fh32 == 32'd0) begin
			last_row = '0;
		end else if (fh32 > 32'(MAX_ROWS)) begin
			last_row = 12'(MAX_ROWS - 1);
		end else begin
			last_row = 12'(fh32 - 32'd1);
		end
		last      = col_q == last_col;
		row_last  = row_q[11:0] == last_row;
		effective = drain_q ? (in_mode == MODE_DRAIN) : (in_mode == MODE_PIXEL);
		mask      = fmt_q ? {PIXEL_BITS{1'b1}} : PIXEL_BITS'(32'h0000_FFFF);
	end

	assign cfg_ready  = 1'b1;
	assign in_ready   = item_ready;
	assign item_valid = in_valid && effective;
	assign accepted   = in_valid && in_ready;

	assign item_ctrl.is_drain  = drain_q;
	assign item_ctrl.emit      = drain_q || (row_q != 13'd0);
	assign item_ctrl.has_upper = row_q >= 13'd2;
	assign item_ctrl.last      = last;
	assign item_ctrl.done      = drain_q && last;
	assign item_ctrl.brow      = 12'(row_q - 13'd1);
	assign item_x              = col_q;
	assign item_nxt            = last ? '0 : col_q + 1'b1;
	assign item_px             = in_pixel[PIXEL_BITS-1:0] & mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q    <= FRAME_WIDTH_RST;
			fh_q    <= FRAME_HEIGHT_RST;
			fmt_q   <= 1'b0;
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					fw_q    <= cfg_data;
					col_q   <= '0;
					row_q   <= '0;
					drain_q <= 1'b0;
				end
				REG_FRAME_HEIGHT: begin
					fh_q    <= cfg_data;
					col_q   <= '0;
					row_q   <= '0;
					drain_q <= 1'b0;
				end
				REG_PIXEL_FORMAT: begin
					fmt_q   <= cfg_data[0];
					col_q   <= '0;
					row_q   <= '0;
					drain_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end else if (accepted && effective) begin
			if (drain_q) begin
				if (last) begin
					col_q   <= '0;
					row_q   <= '0;
					drain_q <= 1'b0;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (last) begin
				col_q <= '0;
				row_q <= row_q + 13'd1;
				if (row_last) begin
					drain_q <= 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

### sv/sc2x_back.sv
// Back end: line buffers, neighbor window, Scale2x corner rules and result register.
module sc2x_back
	import sc2x_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  item_ctrl_t                   item_ctrl,
	input  logic [$clog2(MAX_WIDTH)-1:0] item_x,
	input  logic [$clog2(MAX_WIDTH)-1:0] item_nxt,
	input  logic [PIXEL_BITS-1:0]        item_px,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [PIXEL_BITS-1:0]        res_tl,
	output logic [PIXEL_BITS-1:0]        res_tr,
	output logic [PIXEL_BITS-1:0]        res_bl,
	output logic [PIXEL_BITS-1:0]        res_br,
	output logic [11:0]                  res_col,
	output logic [11:0]                  res_row,
	output logic                         res_done
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic                  en, pop;
	logic                  v_s2;
	item_ctrl_t            ctrl_s2;
	logic [COL_W-1:0]      x_s2, nxt_s2;
	logic [PIXEL_BITS-1:0] px_s2;
	logic                  up_byp_s2, mid_byp_s2;
	logic [PIXEL_BITS-1:0] up_bdat_s2, mid_bdat_s2;
	logic [PIXEL_BITS-1:0] up_rd, mid_rd;
	logic [PIXEL_BITS-1:0] c_q, lc_q;
	logic                  res_valid_q;

	logic                  up_we, mid_we;
	logic [PIXEL_BITS-1:0] up_val, mid_val, c_next;
	logic [PIXEL_BITS-1:0] a, b, c, d, e;
	logic [PIXEL_BITS-1:0] tl, tr, bl, br;

	assign en         = !res_valid_q || res_ready;
	assign pop        = en && item_valid;
	assign item_ready = en;
	assign res_valid  = res_valid_q;
	assign up_we      = en && v_s2 && !ctrl_s2.is_drain && ctrl_s2.emit;
	assign mid_we     = en && v_s2 && !ctrl_s2.is_drain;

	sc2x_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (up_we),
		.waddr (x_s2),
		.wdata (c_q),
		.re    (pop),
		.raddr (item_x),
		.rdata (up_rd)
	);

	sc2x_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (mid_we),
		.waddr (x_s2),
		.wdata (px_s2),
		.re    (pop),
		.raddr (item_nxt),
		.rdata (mid_rd)
	);

	// The middle read fetches the center of the following item; a one-pixel row
	// reads back the pixel this item stores.
	always_comb begin
		up_val  = up_byp_s2 ? up_bdat_s2 : up_rd;
		mid_val = mid_byp_s2 ? mid_bdat_s2 : mid_rd;
		c_next  = (!ctrl_s2.is_drain && (nxt_s2 == x_s2)) ? px_s2 : mid_val;
		c       = c_q;
		d       = ctrl_s2.last ? c : c_next;
		a       = ctrl_s2.has_upper ? up_val : c;
		b       = (x_s2 != '0) ? lc_q : c;
		e       = ctrl_s2.is_drain ? c : px_s2;
		if ((a != e) && (b != d)) begin
			tl = (a == b) ? a : c;
			tr = (a == d) ? a : c;
			bl = (e == b) ? e : c;
			br = (e == d) ? e : c;
		end else begin
			tl = c;
			tr = c;
			bl = c;
			br = c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			v_s2        <= item_valid;
			res_valid_q <= v_s2 && ctrl_s2.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ctrl_s2     <= item_ctrl;
			x_s2        <= item_x;
			nxt_s2      <= item_nxt;
			px_s2       <= item_px;
			up_byp_s2   <= up_we && (x_s2 == item_x);
			up_bdat_s2  <= c_q;
			mid_byp_s2  <= mid_we && (x_s2 == item_nxt);
			mid_bdat_s2 <= px_s2;
		end
		if (en && v_s2) begin
			c_q      <= c_next;
			lc_q     <= c_q;
			res_tl   <= tl;
			res_tr   <= tr;
			res_bl   <= bl;
			res_br   <= br;
			res_col  <= 12'(x_s2);
			res_row  <= ctrl_s2.brow;
			res_done <= ctrl_s2.done;
		end
	end

endmodule

### sv/sc2x_checker.sv
// Port-level assertions for the upscaler and the bind that attaches them.
module sc2x_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [151:0] m_axis_tdata,
	input logic         m_axis_tlast
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result beat changed while stalled");

	// The frame's final block lies in the bottom row, so its down neighbor equals its center.
	a_last_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[95:64] == m_axis_tdata[127:96])
		else $error("final block has unequal bottom pixels");

	// In the first column the left neighbor is the center.
	a_left_edge: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[139:128] == 12'd0)
		|-> m_axis_tdata[31:0] == m_axis_tdata[95:64])
		else $error("left edge block has unequal left pixels");

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

endmodule

bind scale2x_pixel_upscaler sc2x_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

### verif/tb.sv
// Self-checking testbench for the streaming Scale2x pixel upscaler.
module tb;
	import sc2x_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 12;

	// Same bit order as {m_axis_tlast, m_axis_tdata}.
	typedef struct packed {
		logic        frame_done;
		logic [11:0] block_row;
		logic [11:0] block_column;
		logic [31:0] bottom_right;
		logic [31:0] bottom_left;
		logic [31:0] top_right;
		logic [31:0] top_left;
	} scaled_block_t;

	typedef struct packed {
		logic          is_cfg;
		cfg_reg_t      addr;
		logic [12:0]   value;
		logic          mode;
		logic [31:0]   pixel;
		logic          typed;
		scaled_block_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic s_axis_tuser = MODE_PIXEL;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [151:0] m_axis_tdata;
	logic m_axis_tlast;

	scaled_block_t pending_blocks[$];
	script_row_t script[$];
	int fault_count = 0;
	int quiet_cycles = 0;
	int useful_items = 0;
	bit steady = 1'b0;
	logic [31:0] palette [4];
	int wild_pct = 4;

	// Shadow of the upscaler state.
	logic [31:0] upper_row [MAX_WIDTH_DEF];
	logic [31:0] middle_row [MAX_WIDTH_DEF];
	logic [31:0] prev_center;
	int unsigned next_col;
	int unsigned rows_done;
	bit in_drain;
	logic [12:0] width_cfg;
	logic [12:0] height_cfg;
	logic rgb32_cfg;

	scale2x_pixel_upscaler dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] pixel_mask();
		return rgb32_cfg ? 32'hFFFF_FFFF : 32'h0000_FFFF;
	endfunction

	function automatic int unsigned used_width();
		if (width_cfg == 0)
			return 1;
		if (width_cfg > MAX_WIDTH_DEF)
			return MAX_WIDTH_DEF;
		return width_cfg;
	endfunction

	function automatic int unsigned used_height();
		if (height_cfg == 0)
			return 1;
		if (height_cfg > MAX_ROWS)
			return MAX_ROWS;
		return height_cfg;
	endfunction

	function automatic void restart_frame();
		prev_center = '0;
		next_col = 0;
		rows_done = 0;
		in_drain = 1'b0;
	endfunction

	function automatic scaled_block_t epx_corners(logic [31:0] a, logic [31:0] b,
			logic [31:0] c, logic [31:0] d, logic [31:0] e, int unsigned col,
			int unsigned row, logic done);
		scaled_block_t r;
		if (a != e && b != d) begin
			r.top_left = (a == b) ? a : c;
			r.top_right = (a == d) ? a : c;
			r.bottom_left = (e == b) ? e : c;
			r.bottom_right = (e == d) ? e : c;
		end else begin
			r.top_left = c;
			r.top_right = c;
			r.bottom_left = c;
			r.bottom_right = c;
		end
		r.block_column = 12'(col);
		r.block_row = 12'(row);
		r.frame_done = done;
		return r;
	endfunction

	// Advances the shadow state by one input beat; returns 1 when a block is due.
	function automatic bit predict_block(logic mode, logic [31:0] raw,
			output scaled_block_t blk);
		logic [31:0] m, px, a, b, c, d;
		int unsigned w, h, x, brow;
		bit made;
		bit last;
		m = pixel_mask();
		w = used_width();
		h = used_height();
		px = raw & m;
		blk = '0;
		made = 1'b0;
		if (next_col >= w)
			next_col = 0;
		x = next_col;
		c = middle_row[x] & m;
		d = (x + 1 < w) ? (middle_row[x + 1] & m) : c;
		if (mode == MODE_PIXEL) begin
			if (in_drain)
				return 1'b0;
			useful_items++;
			if (rows_done > 0) begin
				a = (rows_done == 1) ? c : (upper_row[x] & m);
				b = (x > 0) ? (prev_center & m) : c;
				blk = epx_corners(a, b, c, d, px, x, rows_done - 1, 1'b0);
				made = 1'b1;
				upper_row[x] = c;
			end
			prev_center = c;
			middle_row[x] = px;
			if (x + 1 >= w) begin
				next_col = 0;
				rows_done++;
				if (rows_done >= h)
					in_drain = 1'b1;
			end else begin
				next_col = x + 1;
			end
			return made;
		end
		if (!in_drain)
			return 1'b0;
		useful_items++;
		brow = (rows_done > 0) ? rows_done - 1 : 0;
		last = (x + 1 >= w);
		a = (brow == 0) ? c : (upper_row[x] & m);
		b = (x > 0) ? (middle_row[x - 1] & m) : c;
		blk = epx_corners(a, b, c, d, c, x, brow, last);
		if (last)
			restart_frame();
		else
			next_col = x + 1;
		return 1'b1;
	endfunction

	function automatic scaled_block_t solid(logic [31:0] c, logic [11:0] col,
			logic [11:0] row, logic done);
		scaled_block_t r;
		r.top_left = c;
		r.top_right = c;
		r.bottom_left = c;
		r.bottom_right = c;
		r.block_column = col;
		r.block_row = row;
		r.frame_done = done;
		return r;
	endfunction

	function automatic script_row_t cfg_row(cfg_reg_t addr, logic [12:0] value);
		script_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.addr = addr;
		r.value = value;
		return r;
	endfunction

	function automatic script_row_t beat_row(logic mode, logic [31:0] px);
		script_row_t r;
		r = '0;
		r.mode = mode;
		r.pixel = px;
		return r;
	endfunction

	function automatic script_row_t checked_row(logic mode, logic [31:0] px,
			scaled_block_t want);
		script_row_t r;
		r = beat_row(mode, px);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic logic [31:0] pick_pixel();
		if ($urandom_range(99) < wild_pct)
			return $urandom();
		return palette[$urandom_range(3)];
	endfunction

	task automatic new_palette();
		palette[0] = $urandom();
		palette[1] = {16'($urandom()), palette[0][15:0]};
		palette[2] = $urandom();
		palette[3] = $urandom();
		wild_pct = ($urandom_range(3) == 0) ? 40 : 4;
	endtask

	task automatic send_beat(logic mode, logic [31:0] px);
		cfg_valid <= 1'b0;
		while (!steady && $urandom_range(99) < 31) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic push_item(logic mode, logic [31:0] px);
		scaled_block_t blk;
		send_beat(mode, px);
		if (predict_block(mode, px, blk))
			pending_blocks.push_back(blk);
	endtask

	// Waits until the block has delivered every block due and has gone quiet.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_blocks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t addr, logic [12:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= addr;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (addr)
			REG_FRAME_WIDTH: width_cfg = value;
			REG_FRAME_HEIGHT: height_cfg = value;
			REG_PIXEL_FORMAT: rgb32_cfg = value[0];
			default: ;
		endcase
		restart_frame();
	endtask

	// Sends pixels in raster order and then the drain ticks, stopping after cut of them.
	task automatic run_frame(int unsigned cut, bit noisy);
		int unsigned w, h, sent;
		w = used_width();
		h = used_height();
		sent = 0;
		for (int unsigned r = 0; r < h; r++) begin
			for (int unsigned c = 0; c < w; c++) begin
				if (sent == cut)
					return;
				if (noisy && $urandom_range(99) < 2)
					push_item(MODE_DRAIN, $urandom());
				if (noisy && $urandom_range(99) < 1)
					settle();
				push_item(MODE_PIXEL, pick_pixel());
				sent++;
			end
		end
		for (int unsigned c = 0; c < w; c++) begin
			if (sent == cut)
				return;
			if (noisy && $urandom_range(99) < 3)
				push_item(MODE_PIXEL, $urandom());
			push_item(MODE_DRAIN, $urandom());
			sent++;
		end
	endtask

	task automatic random_phase();
		int unsigned pick, total, cut;
		logic [12:0] wv, hv;
		pick = $urandom_range(99);
		wv = (pick < 5) ? 13'd0 : (pick < 75) ? 13'($urandom_range(1, 6))
			: 13'($urandom_range(7, 40));
		hv = ($urandom_range(99) < 5) ? 13'd0 : 13'($urandom_range(1, 6));
		pick = $urandom_range(1, 7);
		settle();
		if (pick[0])
			write_reg(REG_FRAME_WIDTH, wv);
		if (pick[1])
			write_reg(REG_FRAME_HEIGHT, hv);
		if (pick[2])
			write_reg(REG_PIXEL_FORMAT, 13'($urandom_range(1)));
		new_palette();
		total = used_width() * used_height() + used_width();
		cut = ($urandom_range(99) < 8) ? $urandom_range(1, total - 1) : total;
		run_frame(cut, 1'b1);
	endtask

	task automatic extreme_phase(logic [12:0] wv, logic [12:0] hv, logic fmt);
		settle();
		write_reg(REG_FRAME_WIDTH, wv);
		write_reg(REG_FRAME_HEIGHT, hv);
		write_reg(REG_PIXEL_FORMAT, {12'd0, fmt});
		new_palette();
		run_frame(used_width() * used_height() + used_width(), 1'b0);
	endtask

	always @(posedge clk)
		m_axis_tready <= steady || ($urandom_range(99) >= 31);

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fault_count++;
			if (fault_count <= 10)
				$display("%s: expected %h, got %h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		scaled_block_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tlast, m_axis_tdata};
			if (pending_blocks.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected block at column %0d row %0d",
						got.block_column, got.block_row);
			end else begin
				want = pending_blocks.pop_front();
				check_field("top_left", want.top_left, got.top_left);
				check_field("top_right", want.top_right, got.top_right);
				check_field("bottom_left", want.bottom_left, got.bottom_left);
				check_field("bottom_right", want.bottom_right, got.bottom_right);
				check_field("block_column", want.block_column, got.block_column);
				check_field("block_row", want.block_row, got.block_row);
				check_field("frame_done", want.frame_done, got.frame_done);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("scale2x_pixel_upscaler: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		scaled_block_t blk;
		int random_goal;
		for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
			upper_row[i] = '0;
			middle_row[i] = '0;
		end
		restart_frame();
		width_cfg = FRAME_WIDTH_RST;
		height_cfg = FRAME_HEIGHT_RST;
		rgb32_cfg = 1'b0;

		// A 2x2 frame in xrgb8888 with stray beats, then a 3x3 rgb565 frame
		// whose centre block takes its corners from the edge neighbours.
		script.push_back(beat_row(MODE_DRAIN, 32'h0));
		script.push_back(cfg_row(REG_PIXEL_FORMAT, 13'd1));
		script.push_back(cfg_row(REG_FRAME_WIDTH, 13'd2));
		script.push_back(cfg_row(REG_FRAME_HEIGHT, 13'd2));
		script.push_back(beat_row(MODE_PIXEL, 32'hFFFF_FFFF));
		script.push_back(beat_row(MODE_PIXEL, 32'h0000_0000));
		script.push_back(beat_row(MODE_DRAIN, 32'hFFFF_FFFF));
		script.push_back(checked_row(MODE_PIXEL, 32'h1234_5678,
			solid(32'hFFFF_FFFF, 12'd0, 12'd0, 1'b0)));
		script.push_back(checked_row(MODE_PIXEL, 32'h0000_0000,
			solid(32'h0000_0000, 12'd1, 12'd0, 1'b0)));
		script.push_back(beat_row(MODE_PIXEL, 32'hA5A5_A5A5));
		script.push_back(beat_row(MODE_DRAIN, 32'h0));
		script.push_back(checked_row(MODE_DRAIN, 32'h0,
			solid(32'h0000_0000, 12'd1, 12'd1, 1'b1)));
		script.push_back(cfg_row(REG_PIXEL_FORMAT, 13'd0));
		script.push_back(cfg_row(REG_FRAME_WIDTH, 13'd3));
		script.push_back(cfg_row(REG_FRAME_HEIGHT, 13'd3));
		script.push_back(beat_row(MODE_PIXEL, 32'hFFFF_0001));
		script.push_back(beat_row(MODE_PIXEL, 32'h0000_0002));
		script.push_back(beat_row(MODE_PIXEL, 32'h0000_0003));
		script.push_back(beat_row(MODE_PIXEL, 32'h0000_0002));
		script.push_back(beat_row(MODE_PIXEL, 32'h0000_0005));
		script.push_back(beat_row(MODE_PIXEL, 32'h0000_0006));
		script.push_back(beat_row(MODE_PIXEL, 32'h0000_0007));
		script.push_back(beat_row(MODE_PIXEL, 32'h0000_0006));
		script.push_back(beat_row(MODE_PIXEL, 32'hABCD_0008));
		script.push_back(beat_row(MODE_DRAIN, 32'h0));
		script.push_back(beat_row(MODE_DRAIN, 32'h0));
		script.push_back(beat_row(MODE_DRAIN, 32'h0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				if (i == 0 || !script[i - 1].is_cfg)
					settle();
				write_reg(script[i].addr, script[i].value);
			end else begin
				send_beat(script[i].mode, script[i].pixel);
				if (predict_block(script[i].mode, script[i].pixel, blk))
					pending_blocks.push_back(script[i].typed ? script[i].want : blk);
			end
		end

		random_goal = useful_items + 650;
		while (useful_items < random_goal)
			random_phase();

		steady = 1'b1;
		extreme_phase(13'd4096, 13'd0, 1'b1);
		steady = 1'b0;
		extreme_phase(13'd0, 13'd4096, 1'b0);
		extreme_phase(13'd8191, 13'd1, 1'b1);
		extreme_phase(13'd1, 13'd8191, 1'b0);

		s_axis_tvalid <= 1'b0;
		while (pending_blocks.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fault_count == 0)
			$display("scale2x_pixel_upscaler: match");
		else
			$display("scale2x_pixel_upscaler: mismatch");
		$finish;
	end

endmodule
